[sv/trv_pkg.sv]
`timescale 1ns / 1ps

package trv_pkg;

	// Rounds per data word and rounds of key/IV mixing after a load
	localparam int WORD_BITS     = 64;
	localparam int WARMUP_ROUNDS = 1152;

	localparam int LEN_A    = 93;
	localparam int LEN_B    = 84;
	localparam int LEN_C    = 111;
	localparam int KEY_BITS = 80;
	localparam int HIGH_W   = KEY_BITS - 64;

	localparam int TEXT_W = 64;
	localparam int CNT_W  = 7;
	localparam int CFG_W  = 64;
	localparam int IDX_W  = 2;

	// Warm-up counter must also hold WORD_BITS for the chunk compare
	localparam int WARM_RAW = $clog2(WARMUP_ROUNDS + 1);
	localparam int WARM_W   = (WARM_RAW > CNT_W) ? WARM_RAW : CNT_W;

	localparam logic [1:0] STAT_DATA    = 2'd0;
	localparam logic [1:0] STAT_INIT    = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	localparam logic FUNC_INIT = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	localparam logic [IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [IDX_W-1:0] CFG_IV_LOW   = 2'd2;
	localparam logic [IDX_W-1:0] CFG_IV_HIGH  = 2'd3;

	typedef struct packed {
		logic [LEN_A-1:0] a;
		logic [LEN_B-1:0] b;
		logic [LEN_C-1:0] c;
	} state_t;

endpackage

[sv/trv_step.sv]
`timescale 1ns / 1ps

// Advances the cipher state by cnt rounds (0..WORD_BITS) in one pass.
// Every tap sits at least 65 positions above the feed point, so all rounds
// of one word read only the incoming state and are computed side by side.
module trv_step (
	input  trv_pkg::state_t                   state_in,
	input  logic [trv_pkg::CNT_W-1:0]         cnt,
	output trv_pkg::state_t                   state_out,
	output logic [trv_pkg::WORD_BITS-1:0]     ks
);

	localparam int WB = trv_pkg::WORD_BITS;
	localparam int LA = trv_pkg::LEN_A;
	localparam int LB = trv_pkg::LEN_B;
	localparam int LC = trv_pkg::LEN_C;

	// feedback bits, newest round at bit 0 (window order)
	logic [WB-1:0] fa, fb, fc;
	logic [WB-1:0] z;

	always_comb begin
		logic [LA-1:0] a;
		logic [LB-1:0] b;
		logic [LC-1:0] c;
		logic          t1, t2, t3;
		a = state_in.a;
		b = state_in.b;
		c = state_in.c;
		for (int k = 0; k < WB; k++) begin
			t1 = a[65-k] ^ a[92-k];
			t2 = b[68-k] ^ b[83-k];
			t3 = c[65-k] ^ c[110-k];
			z[k] = (t1 ^ t2 ^ t3) & (k < int'(cnt));
			fb[WB-1-k] = t1 ^ (a[90-k] & a[91-k]) ^ b[77-k];
			fc[WB-1-k] = t2 ^ (b[81-k] & b[82-k]) ^ c[86-k];
			fa[WB-1-k] = t3 ^ (c[108-k] & c[109-k]) ^ a[68-k];
		end
	end

	assign ks = z;

	// Register after n rounds is the window {old, fed} shifted down by WB - n
	localparam int CNT_W_L = trv_pkg::CNT_W;
	logic [CNT_W_L-1:0] shamt;

	assign shamt = CNT_W_L'(WB) - cnt;

	logic [LA+WB-1:0] wa;
	logic [LB+WB-1:0] wb;
	logic [LC+WB-1:0] wc;

	assign wa = {state_in.a, fa} >> shamt;
	assign wb = {state_in.b, fb} >> shamt;
	assign wc = {state_in.c, fc} >> shamt;

	assign state_out.a = wa[LA-1:0];
	assign state_out.b = wb[LB-1:0];
	assign state_out.c = wc[LC-1:0];

endmodule

[sv/trivium_keystream_cipher_core.sv]
`timescale 1ns / 1ps

// Trivium stream cipher (80-bit key, 80-bit IV). Write the key and IV through
// the config port (index 0 key_low, 1 key_high, 2 iv_low, 3 iv_high), then send
// an init word (func = 0): it loads A with the key, B with the IV, sets the top
// three bits of C, runs 1152 warm-up rounds and returns status 1. Warm-up runs
// 64 rounds per clock (the last chunk waits for the result slot), so an init
// word holds the input stage until warm-up is done. A data word (func = 1)
// advances the cipher by bit_count rounds (0..64, larger counts clamp to 64) and
// returns the keystream (bit 0 = first round, unused high bits zero) and
// text_word XOR keystream over the valid bits, status 0. Encrypt and decrypt are
// the same operation. Data words sent before any init are answered with status
// 2 and leave the cipher untouched. Data words stream at one per clock while the
// output is not stalled, through an input register, the unrolled 64-round step
// and a result register that lets the next word be taken while a result waits.
module trivium_keystream_cipher_core (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_we,
	input  logic [trv_pkg::IDX_W-1:0]        cfg_index,
	input  logic [trv_pkg::CFG_W-1:0]        cfg_data,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [trv_pkg::TEXT_W-1:0]       text_word,
	input  logic [trv_pkg::CNT_W-1:0]        bit_count,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [trv_pkg::TEXT_W-1:0]       keystream_word,
	output logic [trv_pkg::TEXT_W-1:0]       cipher_word,
	output logic [1:0]                       status
);

	localparam int WB = trv_pkg::WORD_BITS;
	localparam int WW = trv_pkg::WARM_W;
	localparam int CW = trv_pkg::CNT_W;
	localparam int TW = trv_pkg::TEXT_W;
	localparam int HW = trv_pkg::HIGH_W;

	// ---- config registers ----
	logic [63:0]   key_low_q, iv_low_q;
	logic [HW-1:0] key_high_q, iv_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trv_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data[63:0];
				trv_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data[HW-1:0];
				trv_pkg::CFG_IV_LOW:   iv_low_q   <= cfg_data[63:0];
				trv_pkg::CFG_IV_HIGH:  iv_high_q  <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// ---- input stage ----
	logic          valid_s1;
	logic          func_s1;
	logic [TW-1:0] text_s1;
	logic [CW-1:0] count_s1;

	// ---- cipher state ----
	trv_pkg::state_t state_q;
	logic            keyed_q;
	logic            warm_act_q;   // init word is part way through warm-up
	logic [WW-1:0]   warm_left_q;

	// ---- result register ----
	logic          out_valid_q;
	logic [TW-1:0] ks_q, ct_q;
	logic [1:0]    status_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// key/IV image loaded at the start of an init word
	trv_pkg::state_t loaded;
	assign loaded.a = {(trv_pkg::LEN_A - trv_pkg::KEY_BITS)'(0), key_high_q, key_low_q};
	assign loaded.b = {(trv_pkg::LEN_B - trv_pkg::KEY_BITS)'(0), iv_high_q, iv_low_q};
	assign loaded.c = {3'b111, (trv_pkg::LEN_C - 3)'(0)};

	logic          is_init;
	logic [WW-1:0] remaining;
	logic          last_chunk;
	logic [CW-1:0] data_cnt;
	logic [CW-1:0] step_cnt;
	logic          emit;
	logic          step_en;

	assign is_init    = (func_s1 == trv_pkg::FUNC_INIT);
	assign remaining  = warm_act_q ? warm_left_q : WW'(trv_pkg::WARMUP_ROUNDS);
	assign last_chunk = (remaining <= WW'(WB));
	assign data_cnt   = (count_s1 > CW'(WB)) ? CW'(WB) : count_s1;

	always_comb begin
		if (is_init)
			step_cnt = last_chunk ? remaining[CW-1:0] : CW'(WB);
		else if (keyed_q)
			step_cnt = data_cnt;
		else
			step_cnt = '0;
	end

	// An init word only needs the result slot on its final chunk
	assign emit    = valid_s1 && out_free && (!is_init || last_chunk);
	assign step_en = valid_s1 && (out_free || (is_init && !last_chunk));

	trv_pkg::state_t     step_src, step_dst;
	logic [WB-1:0]       step_ks;

	assign step_src = (is_init && !warm_act_q) ? loaded : state_q;

	trv_step u_step (
		.state_in  (step_src),
		.cnt       (step_cnt),
		.state_out (step_dst),
		.ks        (step_ks)
	);

	// text bits above the count are dropped
	logic [TW-1:0] text_mask;
	always_comb begin
		for (int i = 0; i < TW; i++)
			text_mask[i] = (i < int'(step_cnt));
	end

	assign in_stall = valid_s1 && !emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			text_s1  <= text_word;
			count_s1 <= bit_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			keyed_q     <= 1'b0;
			warm_act_q  <= 1'b0;
			warm_left_q <= '0;
		end else if (step_en) begin
			state_q <= step_dst;
			if (is_init) begin
				warm_act_q  <= !last_chunk;
				warm_left_q <= remaining - WW'(WB);
				if (last_chunk)
					keyed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_init) begin
				ks_q     <= '0;
				ct_q     <= '0;
				status_q <= trv_pkg::STAT_INIT;
			end else if (!keyed_q) begin
				ks_q     <= '0;
				ct_q     <= '0;
				status_q <= trv_pkg::STAT_REFUSED;
			end else begin
				ks_q     <= TW'(step_ks);
				ct_q     <= (text_s1 & text_mask) ^ TW'(step_ks);
				status_q <= trv_pkg::STAT_DATA;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign keystream_word = ks_q;
	assign cipher_word    = ct_q;
	assign status         = status_q;

endmodule
